[src/zfs_pkg.sv]
package zfs_pkg;

    localparam int NumFeatures = 16;
    localparam int FeatW = 4;
    localparam int MaxRows = 65535;
    localparam int RowW = 16;
    localparam int SumW = 34;
    localparam int SqW = 48;

    localparam logic [1:0] KIND_TRAIN  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_SCALE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNTRAIN  = 2'd1;
    localparam logic [1:0] ST_NOROWS   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // divider operation request
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [47:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [47:0] rem;
    } t_div_rsp;

endpackage

[src/zscore_feature_scaler.sv]
// a scale element runs one 64-step division unless the deviation is zero; a finish item runs
// two 64-step divisions and a 24-step root per feature, for each of the 16 features
// one item at a time; the radix-2 divider is shared by scale and finish items
// result held in an output register until taken; next request accepted when the held result is taken
// reset: synchronous active low, clears sums, count, mean, deviation and trained flag
module zscore_feature_scaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_feature_index,
    input  logic signed [15:0] i_sample_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [14:0] o_scaled_value,
    output logic [1:0]  o_status
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_TRAIN = 10'b0000000010,
        S_SDIV  = 10'b0000000100,
        S_SWAIT = 10'b0000001000,
        S_FMEAN = 10'b0000010000,
        S_FMW   = 10'b0000100000,
        S_FSQ   = 10'b0001000000,
        S_FSQW  = 10'b0010000000,
        S_FRT   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;

    logic signed [zfs_pkg::SumW-1:0] r_sum [zfs_pkg::NumFeatures];
    logic [zfs_pkg::SqW-1:0]         r_sq  [zfs_pkg::NumFeatures];
    logic signed [15:0]              r_mean [zfs_pkg::NumFeatures];
    logic [15:0]                     r_dev  [zfs_pkg::NumFeatures];
    logic [zfs_pkg::RowW-1:0]        r_rows;
    logic                            r_trained;

    logic [zfs_pkg::FeatW-1:0] r_f;
    logic signed [15:0] r_x;
    logic [zfs_pkg::FeatW-1:0] r_fi;
    logic        r_neg;
    logic signed [15:0] r_q;
    logic signed [14:0] r_oval;
    logic [1:0]  r_ost;
    logic        r_ovalid;

    zfs_pkg::t_div_req w_dreq;
    zfs_pkg::t_div_rsp w_drsp;
    logic        w_sstart, w_sdone;
    logic [47:0] w_sval;
    logic [23:0] w_root;

    zfs_divider u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_rsp(w_drsp));
    zfs_sqrt u_sqrt (.i_clk, .i_rst_n, .i_start(w_sstart), .i_val(w_sval),
        .o_done(w_sdone), .o_root(w_root));

    logic accept;
    assign accept = i_valid && !o_stall;
    assign o_stall = r_state != S_IDLE || (r_ovalid && i_stall);

    // scale element arithmetic
    logic signed [18:0] w_m, w_sd3, w_hi, w_lo, w_xc, w_diff;
    logic [18:0] w_adiff;
    always_comb begin
        w_m = 19'(r_mean[r_f]);
        w_sd3 = 19'(signed'({1'b0, r_dev[r_f]})) * 19'sd3;
        w_hi = w_m + w_sd3;
        w_lo = w_m - w_sd3;
        w_xc = 19'(r_x);
        if (w_xc > w_hi) begin
            w_xc = w_hi;
        end else if (w_xc < w_lo) begin
            w_xc = w_lo;
        end
        w_diff = w_xc - w_m;
        w_adiff = w_diff[18] ? 19'(-w_diff) : 19'(w_diff);
    end

    // finish arithmetic
    logic signed [zfs_pkg::SumW-1:0] w_s;
    logic [zfs_pkg::SumW-1:0] w_as;
    logic [63:0] w_qmag;
    logic signed [64:0] w_qs;
    logic signed [15:0] w_qsat;
    logic signed [31:0] w_qw;
    logic [31:0] w_m2;
    logic [63:0] w_var;
    always_comb begin
        w_s = r_sum[r_fi];
        w_as = w_s[zfs_pkg::SumW-1] ? (~w_s + 1'b1) : w_s;
        w_qmag = w_drsp.quo + {63'd0, r_neg && w_drsp.rem != 48'd0};
        w_qs = r_neg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});
        if (w_qs > 65'sd32767) begin
            w_qsat = 16'sh7fff;
        end else if (w_qs < -65'sd32768) begin
            w_qsat = 16'sh8000;
        end else begin
            w_qsat = w_qs[15:0];
        end
        w_qw = 32'(r_q);
        w_m2 = 32'(w_qw * w_qw);
        w_var = w_drsp.quo > {32'd0, w_m2} ? w_drsp.quo - {32'd0, w_m2} : 64'd0;
    end

    // training arithmetic
    logic signed [zfs_pkg::SumW:0] w_tsum;
    logic signed [31:0] w_xw;
    logic [31:0] w_xsq;
    logic [zfs_pkg::SqW:0] w_tsq;
    always_comb begin
        w_tsum = (zfs_pkg::SumW+1)'(r_sum[r_f]) + (zfs_pkg::SumW+1)'(r_x);
        w_xw = 32'(r_x);
        w_xsq = 32'(w_xw * w_xw);
        w_tsq = {1'b0, r_sq[r_f]} + (zfs_pkg::SqW+1)'(w_xsq);
    end

    always_comb begin
        w_dreq.start = 1'b0;
        w_dreq.num = '0;
        w_dreq.den = {32'd0, r_rows};
        w_sstart = 1'b0;
        w_sval = w_var[63:48] != 16'd0 ? 48'hffff_ffff_ffff : w_var[47:0];
        case (r_state)
            S_SDIV: begin
                w_dreq.start = 1'b1;
                w_dreq.num = {33'd0, w_adiff, 12'd0};
                w_dreq.den = {32'd0, r_dev[r_f]};
            end
            S_FMEAN: begin
                w_dreq.start = 1'b1;
                w_dreq.num = 64'(w_as);
            end
            S_FSQ: begin
                w_dreq.start = 1'b1;
                w_dreq.num = 64'(r_sq[r_fi]);
            end
            S_FSQW: w_sstart = w_drsp.done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows <= '0;
            r_trained <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < zfs_pkg::NumFeatures; i++) begin
                r_sum[i] <= '0;
                r_sq[i] <= '0;
                r_mean[i] <= '0;
                r_dev[i] <= '0;
            end
        end else begin
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_f <= i_feature_index;
                        r_x <= i_sample_value;
                        r_fi <= '0;
                        r_oval <= '0;
                        r_ost <= zfs_pkg::ST_OK;
                        case (i_kind)
                            zfs_pkg::KIND_TRAIN: r_state <= S_TRAIN;
                            zfs_pkg::KIND_FINISH: begin
                                if (r_rows == '0) begin
                                    r_ost <= zfs_pkg::ST_NOROWS;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_FMEAN;
                                end
                            end
                            zfs_pkg::KIND_SCALE: begin
                                if (!r_trained) begin
                                    r_ost <= zfs_pkg::ST_UNTRAIN;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_SDIV;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_TRAIN: begin
                    r_state <= S_OUT;
                    if (r_f == '0 && r_rows == zfs_pkg::RowW'(zfs_pkg::MaxRows)) begin
                        r_ost <= zfs_pkg::ST_OVERFLOW;
                    end else begin
                        if (r_f == '0) begin
                            r_rows <= r_rows + 1'b1;
                        end
                        if (w_tsum[zfs_pkg::SumW] != w_tsum[zfs_pkg::SumW-1]) begin
                            r_sum[r_f] <= w_tsum[zfs_pkg::SumW]
                                ? {1'b1, {(zfs_pkg::SumW-1){1'b0}}}
                                : {1'b0, {(zfs_pkg::SumW-1){1'b1}}};
                        end else begin
                            r_sum[r_f] <= w_tsum[zfs_pkg::SumW-1:0];
                        end
                        r_sq[r_f] <= w_tsq[zfs_pkg::SqW] ? '1 : w_tsq[zfs_pkg::SqW-1:0];
                    end
                end
                S_SDIV: begin
                    if (r_dev[r_f] == 16'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_neg <= w_diff[18];
                        r_state <= S_SWAIT;
                    end
                end
                S_SWAIT: begin
                    if (w_drsp.done) begin
                        r_oval <= r_neg ? 15'(-w_drsp.quo[14:0]) : w_drsp.quo[14:0];
                        r_state <= S_OUT;
                    end
                end
                S_FMEAN: begin
                    r_neg <= w_s[zfs_pkg::SumW-1];
                    r_state <= S_FMW;
                end
                S_FMW: begin
                    if (w_drsp.done) begin
                        r_q <= w_qsat;
                        r_state <= S_FSQ;
                    end
                end
                S_FSQ: r_state <= S_FSQW;
                S_FSQW: begin
                    if (w_drsp.done) begin
                        r_state <= S_FRT;
                    end
                end
                S_FRT: begin
                    if (w_sdone) begin
                        r_mean[r_fi] <= r_q;
                        r_dev[r_fi] <= w_root[23:16] != 8'd0 ? 16'hffff : w_root[15:0];
                        r_sum[r_fi] <= '0;
                        r_sq[r_fi] <= '0;
                        if (r_fi == zfs_pkg::FeatW'(zfs_pkg::NumFeatures - 1)) begin
                            r_rows <= '0;
                            r_trained <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_fi <= r_fi + 1'b1;
                            r_state <= S_FMEAN;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_scaled_value = r_oval;
    assign o_status = r_ost;

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("request taken while busy");
    a_train_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRT && w_sdone && r_fi == zfs_pkg::FeatW'(zfs_pkg::NumFeatures - 1))
        |=> r_trained && r_rows == '0) else $error("finish did not mark trained");
    a_rows_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= zfs_pkg::RowW'(zfs_pkg::MaxRows)) else $error("row count overflow");

endmodule

[src/zfs_divider.sv]
module zfs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zfs_pkg::t_div_req i_req,
    output zfs_pkg::t_div_rsp o_rsp
);

    logic [63:0] r_quo, n_quo;
    logic [48:0] r_rem, n_rem;
    logic [47:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [48:0] w_trial;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[47:0], r_quo[63]};
        if (r_busy) begin
            n_quo = {r_quo[62:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_trial;
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt <= 7'd64;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_quo;
    assign o_rsp.rem = r_rem[47:0];

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == 7'd0 || $past(i_req.start) == 1'b0)
        else $error("divider count");

endmodule

[src/zfs_sqrt.sv]
module zfs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_val,
    output logic        o_done,
    output logic [23:0] o_root
);

    logic [47:0] r_v, n_v;
    logic [47:0] r_res, n_res;
    logic [47:0] r_bit;
    logic        r_busy, r_done;
    logic [47:0] w_sum;

    always_comb begin
        w_sum = r_res + r_bit;
        n_v = r_v;
        if (r_v >= w_sum) begin
            n_v = r_v - w_sum;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit == 48'd1;
            if (r_bit == 48'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_val;
            r_res <= '0;
            r_bit <= 48'h4000_0000_0000;
        end else if (r_busy) begin
            r_v <= n_v;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[23:0];

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("sqrt done held");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("sqrt done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("sqrt not started");

endmodule
